// File: src/rfr_pkg.sv
// Shared types and constants for the radio frame receiver.
// No dependencies; compile before the interfaces and modules.
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

  localparam int PayloadMaxDefault = 16;
  localparam logic [7:0] NetIdReset = 8'h01;

  // APB register map: one word per register
  localparam int ApbAddrW = 3;
  localparam logic RegNetworkId = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_BUSY     = 2'd1,
    ST_RECEIVED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    logic wr_en;   // store one buffer entry
    logic rd_en;   // refresh the registered read port
    logic rd_hit;  // this transfer is a read of an in-range entry
  } buf_ctl_t;

endpackage

`default_nettype wire

// File: src/rfr_in_if.sv
// Input channel of the radio frame receiver: valid/ready plus one command.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [4:0] read_index;

  modport source (output valid, output operation, output data_byte, output read_index,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input read_index,
                output ready);
endinterface

`default_nettype wire

// File: src/rfr_out_if.sv
// Result channel of the radio frame receiver: valid/ready plus status and read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] read_data;

  modport source (output valid, output frame_status, output read_data, input ready);
  modport sink (input valid, input frame_status, input read_data, output ready);
endinterface

`default_nettype wire

// File: src/rfr_buf.sv
// Receive buffer: one synchronous memory, one write and one registered read port.
// Entries never written read as zero through per-entry valid bits. Uses rfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfr_buf #(
  parameter int Depth = rfr_pkg::PayloadMaxDefault + 1,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rfr_pkg::buf_ctl_t ctl_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic [AddrW-1:0]  rd_addr_i,
  output logic      [7:0]        rd_data_o
);
  import rfr_pkg::*;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        hit_q <= ctl_i.rd_hit & valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? rdata_q : 8'h00;

endmodule

`default_nettype wire

// File: src/radio_frame_receiver_unit.sv
// Radio frame receiver top level: frame checker, result register, APB register.
// Depends on rfr_pkg, rfr_in_if, rfr_out_if and rfr_buf.
//
// Usage:
//   in_i carries one command per transfer: a received radio byte, a read of
//   one buffer entry (0 is the length, 1..n the payload) or a release of a
//   held frame. out_o returns exactly one result per command: the frame
//   status after the command and, for a read, the buffer entry (else 0).
//   The result is valid in the cycle after the input transfer. Throughput is one
//   command per cycle unless results stall; the buffer memory is written and
//   read in the cycle of the transfer, so a read right after a byte sees that
//   byte. A stalled result is held in the output register; a new command is
//   taken in the same cycle the held result leaves, so stalls cost no bubbles.
//   Reset clears the status to idle, the counters and the buffer valid bits,
//   so every entry reads as zero until written; network_id resets to 1 and
//   sits at APB byte address 0. Users write it only while idle (unenforced).
`timescale 1ns / 1ps
`default_nettype none

module radio_frame_receiver_unit #(
  parameter int PAYLOAD_MAX = rfr_pkg::PayloadMaxDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rfr_in_if.sink                            in_i,
  rfr_out_if.source                         out_o,
  input  wire logic                         psel_i,
  input  wire logic                         penable_i,
  input  wire logic                         pwrite_i,
  input  wire logic [rfr_pkg::ApbAddrW-1:0] paddr_i,
  input  wire logic [31:0]                  pwdata_i,
  output logic      [31:0]                  prdata_o,
  output logic                              pready_o
);
  import rfr_pkg::*;

  localparam int Depth = PAYLOAD_MAX + 1;
  localparam int IdxW  = $clog2(Depth);
  localparam int CmpW  = (IdxW > 5) ? IdxW : 5;

  // configuration register
  logic [7:0] net_id_q;
  logic       reg_sel;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[2] == RegNetworkId);
  assign prdata_o = reg_sel ? {24'h000000, net_id_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_id_q <= NetIdReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      net_id_q <= pwdata_i[7:0];
    end
  end

  // handshake and output register
  logic    accept;
  logic    out_valid_q;
  status_e out_status_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // frame state
  status_e    status_q, status_d;
  logic [IdxW-1:0] len_q, len_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;

  buf_ctl_t        buf_ctl;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  logic [CmpW-1:0] idx_w;
  logic            idx_ok;
  logic [7:0]      b;
  logic [IdxW-1:0] cnt_inc;

  assign b       = in_i.data_byte;
  assign idx_w   = CmpW'(in_i.read_index);
  assign idx_ok  = idx_w <= CmpW'(PAYLOAD_MAX);
  assign rd_addr = idx_ok ? idx_w[IdxW-1:0] : '0;
  assign cnt_inc = cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_IDLE;
      len_q    <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
    end else if (accept) begin
      status_q <= status_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
    end
  end

  always_comb begin
    status_d       = status_q;
    len_d          = len_q;
    cnt_d          = cnt_q;
    sum_d          = sum_q;
    buf_ctl.wr_en  = 1'b0;
    buf_ctl.rd_en  = accept;
    buf_ctl.rd_hit = 1'b0;
    wr_addr        = '0;

    case (op_e'(in_i.operation))
      OP_BYTE: begin
        case (status_q)
          ST_IDLE: begin
            status_d = (b == net_id_q) ? ST_BUSY : ST_IDLE;
            len_d    = '0;
            cnt_d    = '0;
            sum_d    = '0;
          end
          ST_BUSY: begin
            if (len_q == '0 && b != 8'h00 && b <= 8'(PAYLOAD_MAX)) begin
              // length byte goes to entry 0
              len_d         = b[IdxW-1:0];
              sum_d         = b;
              buf_ctl.wr_en = accept;
              wr_addr       = '0;
            end else if (cnt_q < len_q) begin
              cnt_d         = cnt_inc;
              sum_d         = sum_q + b;
              buf_ctl.wr_en = accept;
              wr_addr       = cnt_inc;
            end else begin
              // checksum byte; an empty frame ends here on a zero byte
              status_d = (cnt_q == len_q && sum_q == b) ? ST_RECEIVED : ST_IDLE;
              len_d    = '0;
              cnt_d    = '0;
              sum_d    = '0;
            end
          end
          default: ;  // hold while a frame is received
        endcase
      end
      OP_READ: begin
        buf_ctl.rd_hit = idx_ok;
      end
      OP_RELEASE: begin
        if (status_q == ST_RECEIVED) begin
          status_d = ST_IDLE;
          len_d    = '0;
          cnt_d    = '0;
          sum_d    = '0;
        end
      end
      default: ;
    endcase
  end

  rfr_buf #(
    .Depth (Depth),
    .AddrW (IdxW)
  ) u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (buf_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (b),
    .rd_addr_i (rd_addr),
    .rd_data_o (out_o.read_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_status = out_status_q;

endmodule

`default_nettype wire
